### rtl/brl_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package brl_pkg;

  // Coordinate width of the endpoint and pixel fields.
  localparam int COORD_BITS = 12;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // Step size register and its usable range.
  localparam int STEP_BITS = 7;
  localparam logic [STEP_BITS-1:0] STEP_MIN = STEP_BITS'(1);
  localparam logic [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(64);

  // Internal widths: the major coordinate may overshoot the end by one step,
  // the minor coordinate may leave the range on either side, and the
  // decision value spans twice the largest delta in both directions.
  localparam int MAJ_BITS = COORD_BITS + 1;
  localparam int MIN_BITS = COORD_BITS + 3;
  localparam int DEC_BITS = COORD_BITS + 4;

  // Input item action codes.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } brl_action_t;

  // Input item payload.
  typedef struct packed {
    brl_action_t           action;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } brl_in_t;

  // Result item payload.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } brl_out_t;

  // Line setup computed from a load transaction.
  typedef struct packed {
    logic                       busy;
    logic                       major_is_y;
    logic                       minor_down;
    logic [MAJ_BITS-1:0]        cur_major;
    logic signed [MIN_BITS-1:0] cur_minor;
    logic [COORD_BITS-1:0]      end_major;
    logic signed [DEC_BITS-1:0] decision;
    logic signed [DEC_BITS-1:0] incr_straight;
    logic signed [DEC_BITS-1:0] incr_diagonal;
  } brl_line_t;

  // Walker status seen by the top level.
  typedef struct packed {
    logic busy;
    logic major_is_y;
  } brl_status_t;

endpackage

### rtl/brl_setup.sv
// Line setup: axis choice, endpoint ordering, decision value and increments.
module brl_setup import brl_pkg::*; (
  input  brl_in_t   in_item,
  output brl_line_t line
);

  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS-1:0]        ady;
  logic                         major_is_y;
  logic [COORD_BITS-1:0]        a0, b0, a1, b1;
  logic [COORD_BITS-1:0]        p0, q0, p1, q1;
  logic                         swap;
  logic [COORD_BITS-1:0]        dmaj;
  logic signed [COORD_BITS:0]   dmin;
  logic [COORD_BITS-1:0]        admin;
  logic signed [COORD_BITS:0]   dmin_minus_maj;
  logic signed [COORD_BITS+1:0] dec0;

  // Absolute deltas pick the major axis; ties go to y.
  always_comb begin
    dx  = $signed({1'b0, in_item.end_x}) - $signed({1'b0, in_item.start_x});
    dy  = $signed({1'b0, in_item.end_y}) - $signed({1'b0, in_item.start_y});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    major_is_y = !(ady < adx);
  end

  // Map to major/minor coordinates and order the endpoints by major.
  always_comb begin
    if (major_is_y) begin
      p0 = in_item.start_y; q0 = in_item.start_x;
      p1 = in_item.end_y;   q1 = in_item.end_x;
    end else begin
      p0 = in_item.start_x; q0 = in_item.start_y;
      p1 = in_item.end_x;   q1 = in_item.end_y;
    end
    swap = p0 > p1;
    a0 = swap ? p1 : p0;
    b0 = swap ? q1 : q0;
    a1 = swap ? p0 : p1;
    b1 = swap ? q0 : q1;
  end

  // Deltas, decision value and increments.
  always_comb begin
    dmaj  = a1 - a0;
    dmin  = $signed({1'b0, b1}) - $signed({1'b0, b0});
    admin = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : dmin[COORD_BITS-1:0];
    dmin_minus_maj = $signed({1'b0, admin}) - $signed({1'b0, dmaj});
    dec0 = $signed({1'b0, admin, 1'b0}) - $signed({2'b00, dmaj});

    line.busy          = a0 < a1;
    line.major_is_y    = major_is_y;
    line.minor_down    = dmin[COORD_BITS];
    line.cur_major     = {1'b0, a0};
    line.cur_minor     = $signed({{(MIN_BITS-COORD_BITS){1'b0}}, b0});
    line.end_major     = a1;
    line.decision      = DEC_BITS'(dec0);
    line.incr_straight = $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, admin, 1'b0});
    line.incr_diagonal = DEC_BITS'($signed({dmin_minus_maj, 1'b0}));
  end

endmodule

### rtl/brl_walker.sv
// Line state registers and the step of step_size pixels with output saturation.
module brl_walker import brl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  brl_line_t            line,
  input  logic                 step,
  input  logic [STEP_BITS-1:0] step_size,
  output logic                 res_push,
  output brl_out_t             res_data,
  output brl_status_t          status
);

  logic                       busy_r, busy_nxt;
  logic                       major_is_y_r, major_is_y_nxt;
  logic                       minor_down_r, minor_down_nxt;
  logic [MAJ_BITS-1:0]        cur_major_r, cur_major_nxt;
  logic signed [MIN_BITS-1:0] cur_minor_r, cur_minor_nxt;
  logic [COORD_BITS-1:0]      end_major_r, end_major_nxt;
  logic signed [DEC_BITS-1:0] decision_r, decision_nxt;
  logic signed [DEC_BITS-1:0] incr_straight_r, incr_straight_nxt;
  logic signed [DEC_BITS-1:0] incr_diagonal_r, incr_diagonal_nxt;

  logic                       do_step;
  logic [MAJ_BITS-1:0]        step_major;
  logic [MAJ_BITS-1:0]        major_adv;
  logic signed [MIN_BITS-1:0] step_minor;
  logic signed [MIN_BITS-1:0] minor_adv;
  logic signed [DEC_BITS-1:0] decision_adv;
  logic                       last;
  logic [COORD_BITS-1:0]      pix_major;
  logic [COORD_BITS-1:0]      pix_minor;

  // One step: move the major axis, and the minor axis on a positive decision.
  always_comb begin
    do_step    = step && busy_r;
    step_major = MAJ_BITS'(step_size);
    step_minor = $signed({{(MIN_BITS-STEP_BITS){1'b0}}, step_size});
    major_adv  = cur_major_r + step_major;
    if (decision_r > 0) begin
      decision_adv = decision_r + incr_diagonal_r;
      minor_adv    = minor_down_r ? cur_minor_r - step_minor : cur_minor_r + step_minor;
    end else begin
      decision_adv = decision_r + incr_straight_r;
      minor_adv    = cur_minor_r;
    end
    last = major_adv >= {1'b0, end_major_r};
  end

  // Saturate the new position to the coordinate range.
  always_comb begin
    pix_major = major_adv[MAJ_BITS-1] ? COORD_MAX : major_adv[COORD_BITS-1:0];
    if (minor_adv < 0) begin
      pix_minor = '0;
    end else if (minor_adv > $signed({{(MIN_BITS-COORD_BITS){1'b0}}, COORD_MAX})) begin
      pix_minor = COORD_MAX;
    end else begin
      pix_minor = minor_adv[COORD_BITS-1:0];
    end
    res_push            = do_step;
    res_data.pixel_x    = major_is_y_r ? pix_minor : pix_major;
    res_data.pixel_y    = major_is_y_r ? pix_major : pix_minor;
    res_data.last_pixel = last;
  end

  // Next state: a load replaces the line, a step advances it.
  always_comb begin
    busy_nxt          = busy_r;
    major_is_y_nxt    = major_is_y_r;
    minor_down_nxt    = minor_down_r;
    cur_major_nxt     = cur_major_r;
    cur_minor_nxt     = cur_minor_r;
    end_major_nxt     = end_major_r;
    decision_nxt      = decision_r;
    incr_straight_nxt = incr_straight_r;
    incr_diagonal_nxt = incr_diagonal_r;
    if (load) begin
      busy_nxt          = line.busy;
      major_is_y_nxt    = line.major_is_y;
      minor_down_nxt    = line.minor_down;
      cur_major_nxt     = line.cur_major;
      cur_minor_nxt     = line.cur_minor;
      end_major_nxt     = line.end_major;
      decision_nxt      = line.decision;
      incr_straight_nxt = line.incr_straight;
      incr_diagonal_nxt = line.incr_diagonal;
    end else if (do_step) begin
      busy_nxt      = !last;
      cur_major_nxt = major_adv;
      cur_minor_nxt = minor_adv;
      decision_nxt  = decision_adv;
    end
  end

  // Control state resets; the line values are loaded before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      major_is_y_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      major_is_y_r <= major_is_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    minor_down_r    <= minor_down_nxt;
    cur_major_r     <= cur_major_nxt;
    cur_minor_r     <= cur_minor_nxt;
    end_major_r     <= end_major_nxt;
    decision_r      <= decision_nxt;
    incr_straight_r <= incr_straight_nxt;
    incr_diagonal_r <= incr_diagonal_nxt;
  end

  assign status.busy       = busy_r;
  assign status.major_is_y = major_is_y_r;

endmodule

### rtl/brl_obuf.sv
// Output register with a skid stage so input acceptance does not wait on out_ready.
module brl_obuf import brl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  brl_out_t push_data,
  output logic     can_accept,
  output logic     out_valid,
  input  logic     out_ready,
  output brl_out_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  brl_out_t out_data_r, out_data_nxt;
  brl_out_t skid_data_r, skid_data_nxt;
  logic     pop;

  // Refill the output register from the skid stage first, then from a new push.
  always_comb begin
    pop            = out_valid_r && out_ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_accept = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

### rtl/bresenham_line_rasterizer_core.sv
// Top level of the Bresenham line rasterizer.
// A step transaction's pixel is registered in the output register, or in the skid stage while out_data is held.
// Throughput: one transaction per cycle while in_ready is high; the line state update is a registered loop.
// The input stalls only when both the output register and the skid stage are full.
// Reset (synchronous, rst_n low): no line active, no pending results, step size 1.
module bresenham_line_rasterizer_core import brl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  brl_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brl_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [STEP_BITS-1:0] cfg_data
);

  logic [STEP_BITS-1:0] step_size_r, step_size_nxt;
  logic                 in_fire;
  logic                 load;
  logic                 step;
  brl_line_t            line;
  logic                 res_push;
  brl_out_t             res_data;
  brl_status_t          status;

  // Step size register, held already clamped to its usable range.
  assign cfg_ready = 1'b1;

  always_comb begin
    step_size_nxt = step_size_r;
    if (cfg_valid) begin
      priority if (cfg_data < STEP_MIN) begin
        step_size_nxt = STEP_MIN;
      end else if (cfg_data > STEP_MAX) begin
        step_size_nxt = STEP_MAX;
      end else begin
        step_size_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_MIN;
    end else begin
      step_size_r <= step_size_nxt;
    end
  end

  // Decode the accepted transaction.
  assign in_fire = in_valid && in_ready;
  assign load    = in_fire && (in_data.action == ACT_LOAD);
  assign step    = in_fire && (in_data.action == ACT_STEP);

  brl_setup u_setup (
    .in_item (in_data),
    .line    (line)
  );

  brl_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .line      (line),
    .step      (step),
    .step_size (step_size_r),
    .res_push  (res_push),
    .res_data  (res_data),
    .status    (status)
  );

  brl_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res_data),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A pixel is only produced by a step on an active line.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (step && status.busy))
    else $error("pixel produced without an active line");

  // The last pixel of a line leaves the walker idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.last_pixel) |=> !status.busy)
    else $error("line still active after its last pixel");

  // The input only stalls while a result is waiting at the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

  // The step size register always holds a usable value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_size_r >= STEP_MIN) && (step_size_r <= STEP_MAX))
    else $error("step size out of range");

endmodule
